FILE: rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the max-tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_TOP  = 2'd2,
        CMD_MAX  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch item, start top-entry read
        logic execute;  // update store, load result register
    } t_ctrl;

    // one stack entry: running max beside the value
    typedef struct packed {
        logic [DATA_W-1:0] max_val;
        logic [DATA_W-1:0] val;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/core/mts_if.sv
// ----------------------------------------------------------------------------
// mts_in_if / mts_out_if
// Valid/ready channels for stack commands and stack results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mts_in_if;
    logic                        valid;
    logic                        ready;
    logic [mts_pkg::CMD_W-1:0]   command;
    logic [mts_pkg::DATA_W-1:0]  push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface mts_out_if;
    logic                        valid;
    logic                        ready;
    logic [mts_pkg::DATA_W-1:0]  read_data;
    logic [mts_pkg::STAT_W-1:0]  status;
    logic [mts_pkg::COUNT_W-1:0] entry_count;

    modport source (output valid, output read_data, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input entry_count,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer: accept item, wait for top-entry read, hold result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mts_pkg::t_ctrl      o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = (r_state == S_DONE);
    assign o_ctrl.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_ctrl.execute = (r_state == S_READ);

endmodule

`default_nettype wire

FILE: rtl/core/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Stack datapath: entry memory, fill count, max compare, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mts_pkg::t_ctrl              i_ctrl,
    input  wire logic [mts_pkg::CMD_W-1:0]   i_command,
    input  wire logic [mts_pkg::DATA_W-1:0]  i_push_value,
    output logic [mts_pkg::DATA_W-1:0]       o_read_data,
    output logic [mts_pkg::STAT_W-1:0]       o_status,
    output logic [mts_pkg::COUNT_W-1:0]      o_entry_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mts_pkg::t_entry r_mem [DEPTH];

    mts_pkg::t_cmd               r_cmd;
    logic [mts_pkg::DATA_W-1:0]  r_val;
    mts_pkg::t_entry             r_top;
    logic [CW-1:0]               r_fill;
    logic [CW-1:0]               n_fill;
    logic [mts_pkg::DATA_W-1:0]  r_data;
    logic [mts_pkg::DATA_W-1:0]  n_data;
    mts_pkg::t_status            r_status;
    mts_pkg::t_status            n_status;

    logic                        wr_en;
    mts_pkg::t_entry             wr_entry;
    logic [CW-1:0]               fill_dec;
    logic                        is_empty;
    logic                        is_full;
    logic                        new_wins;

    assign fill_dec = r_fill - CW'(1);
    assign is_empty = (r_fill == '0);
    assign is_full  = (r_fill == CW'(DEPTH));
    // tie keeps the entry below
    assign new_wins = $signed(r_val) > $signed(r_top.max_val);

    always_comb begin
        n_fill         = r_fill;
        n_data         = '0;
        n_status       = mts_pkg::ST_OK;
        wr_en          = 1'b0;
        wr_entry.val   = r_val;
        wr_entry.max_val = (is_empty || new_wins) ? r_val : r_top.max_val;
        if (r_cmd == mts_pkg::CMD_PUSH) begin
            if (is_full) begin
                n_status = mts_pkg::ST_FULL;
            end else begin
                wr_en  = i_ctrl.execute;
                n_fill = r_fill + CW'(1);
            end
        end else if (is_empty) begin
            n_status = mts_pkg::ST_EMPTY;
        end else begin
            case (r_cmd)
                mts_pkg::CMD_POP: begin
                    n_data = r_top.val;
                    n_fill = fill_dec;
                end
                mts_pkg::CMD_TOP: begin
                    n_data = r_top.val;
                end
                mts_pkg::CMD_MAX: begin
                    n_data = r_top.max_val;
                end
                default: begin
                    n_data = '0;
                end
            endcase
        end
    end

    // top-entry read is issued with the capture; fill is stable until execute
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= mts_pkg::t_cmd'(i_command);
            r_val <= i_push_value;
            r_top <= r_mem[fill_dec[AW-1:0]];
        end
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= wr_entry;
        end
        if (i_ctrl.execute) begin
            r_data   <= n_data;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctrl.execute) begin
            r_fill <= n_fill;
        end
    end

    assign o_read_data   = r_data;
    assign o_status      = r_status;
    assign o_entry_count = mts_pkg::COUNT_W'(r_fill);

endmodule

`default_nettype wire

FILE: rtl/core/max_tracking_stack.sv
// Sequence: an accepted item is captured in S_IDLE, executed in S_READ and its result
// presented in S_DONE. A new item is accepted only after the result is taken;
//   the top-entry read is registered ahead of the compare and update.
// Reset: synchronous, active low; empties the stack, entry memory not cleared.
// ----------------------------------------------------------------------------
// max_tracking_stack
// LIFO of signed values with a running maximum kept per depth.
// ----------------------------------------------------------------------------
`default_nettype none

module max_tracking_stack #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mts_in_if.sink      i_cmd,
    mts_out_if.source   o_res
);

    mts_pkg::t_ctrl ctrl;

    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_ctrl      (ctrl)
    );

    mts_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_command     (i_cmd.command),
        .i_push_value  (i_cmd.push_value),
        .o_read_data   (o_res.read_data),
        .o_status      (o_res.status),
        .o_entry_count (o_res.entry_count)
    );

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |-> ##2 o_res.valid)
        else $error("result not presented two cycles after accept");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == mts_pkg::ST_EMPTY)) |->
        (o_res.entry_count == '0) && (o_res.read_data == '0))
        else $error("empty status with nonzero count or data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == mts_pkg::ST_FULL)) |->
        (o_res.entry_count == mts_pkg::COUNT_W'(DEPTH)) && (o_res.read_data == '0))
        else $error("full status with wrong count or data");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for max_tracking_stack. A class mirrors the stack and
// its per-depth running maximum and queues one expected reply per accepted
// command. A directed opening covers the empty case, signed extremes and ties.
// Biased random bursts then fill and drain the stack under
// varying source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned BURSTS      = 12;
    localparam int unsigned BURST_LEN   = 120;
    localparam int unsigned DRAIN_LIMIT = 20000;

    typedef struct packed {
        logic [mts_pkg::DATA_W-1:0]  data;
        mts_pkg::t_status            status;
        logic [mts_pkg::COUNT_W-1:0] count;
    } t_reply;

    // Mirror of the stack: value and running max per depth.
    class max_stack_tracker;
        logic signed [mts_pkg::DATA_W-1:0] vals[STACK_DEPTH];
        logic signed [mts_pkg::DATA_W-1:0] maxes[STACK_DEPTH];
        int unsigned fill;
        t_reply      pending_replies[$];
        int unsigned mismatches;
        int unsigned replies_seen;
        int unsigned commands_taken;
        int unsigned pushes_stored;
        int unsigned pushes_refused;
        int unsigned empty_replies;
        int unsigned deepest;

        function void note_command(mts_pkg::t_cmd cmd,
                                   logic signed [mts_pkg::DATA_W-1:0] value);
            t_reply r;
            r.data   = '0;
            r.status = mts_pkg::ST_OK;
            commands_taken++;
            if (cmd == mts_pkg::CMD_PUSH) begin
                if (fill >= STACK_DEPTH) begin
                    r.status = mts_pkg::ST_FULL;
                    pushes_refused++;
                end else begin
                    vals[fill]  = value;
                    maxes[fill] = value;
                    // tie keeps the entry below; same bits either way
                    if (fill > 0) begin
                        if (!(value > maxes[fill-1]))
                            maxes[fill] = maxes[fill-1];
                    end
                    fill++;
                    pushes_stored++;
                    if (fill > deepest)
                        deepest = fill;
                end
            end else if (fill == 0) begin
                r.status = mts_pkg::ST_EMPTY;
                empty_replies++;
            end else begin
                case (cmd)
                    mts_pkg::CMD_POP: begin
                        r.data = vals[fill-1];
                        fill--;
                    end
                    mts_pkg::CMD_TOP: r.data = vals[fill-1];
                    default: r.data = maxes[fill-1];
                endcase
            end
            r.count = mts_pkg::COUNT_W'(fill);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [mts_pkg::DATA_W-1:0] data,
                                  logic [mts_pkg::STAT_W-1:0] status,
                                  logic [mts_pkg::COUNT_W-1:0] count);
            t_reply e;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                $display("%0t: reply with nothing expected: data %0d status %0d count %0d",
                         $time, $signed(data), status, count);
                return;
            end
            e = pending_replies.pop_front();
            if (data !== e.data) begin
                mismatches++;
                $display("%0t: read_data expected %0d got %0d",
                         $time, $signed(e.data), $signed(data));
            end
            if (status !== e.status) begin
                mismatches++;
                $display("%0t: status expected %0d got %0d", $time, e.status, status);
            end
            if (count !== e.count) begin
                mismatches++;
                $display("%0t: entry_count expected %0d got %0d", $time, e.count, count);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mts_in_if  cmd_if();
    mts_out_if res_if();

    max_tracking_stack #(.DEPTH(STACK_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    max_stack_tracker tracker = new();

    // idle mix: none, source gaps, sink stalls, both light
    int unsigned idle_phase = 0;
    int unsigned gap_pct[4]   = '{0, 53, 0, 11};
    int unsigned stall_pct[4] = '{0, 0, 53, 11};

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct[idle_phase]);
        if (i_rst_n && res_if.valid && res_if.ready)
            tracker.check_reply(res_if.read_data, res_if.status, res_if.entry_count);
    end

    task automatic send_command(input mts_pkg::t_cmd cmd,
                                input logic [mts_pkg::DATA_W-1:0] value);
        while ($urandom_range(0, 99) < gap_pct[idle_phase]) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.command    <= cmd;
        cmd_if.push_value <= value;
        do @(posedge i_clk); while (!cmd_if.ready);
        tracker.note_command(cmd, value);
    endtask

    // half the values small so ties and sign changes are common
    function automatic logic [mts_pkg::DATA_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: return $urandom;
            4: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return mts_pkg::DATA_W'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    // burst style 0: filling, 1: mixed, 2: draining
    function automatic mts_pkg::t_cmd pick_command(int unsigned style);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        roll     = $urandom_range(0, 99);
        push_pct = (style == 0) ? 70 : (style == 1) ? 40 : 15;
        pop_pct  = (style == 0) ? 10 : (style == 1) ? 30 : 65;
        if (roll < push_pct)
            return mts_pkg::CMD_PUSH;
        else if (roll < push_pct + pop_pct)
            return mts_pkg::CMD_POP;
        else if (roll < push_pct + pop_pct + (100 - push_pct - pop_pct) / 2)
            return mts_pkg::CMD_TOP;
        return mts_pkg::CMD_MAX;
    endfunction

    initial begin
        int unsigned waited;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.command    <= mts_pkg::CMD_PUSH;
        cmd_if.push_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reads on an empty stack
        send_command(mts_pkg::CMD_POP, $urandom);
        send_command(mts_pkg::CMD_TOP, $urandom);
        send_command(mts_pkg::CMD_MAX, $urandom);
        // signed extremes and ties
        send_command(mts_pkg::CMD_PUSH, 32'h8000_0000);
        send_command(mts_pkg::CMD_MAX,  $urandom);
        send_command(mts_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_command(mts_pkg::CMD_MAX,  $urandom);
        send_command(mts_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        send_command(mts_pkg::CMD_TOP,  $urandom);
        send_command(mts_pkg::CMD_MAX,  $urandom);
        send_command(mts_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_command(mts_pkg::CMD_MAX,  $urandom);
        send_command(mts_pkg::CMD_POP,  $urandom);
        send_command(mts_pkg::CMD_POP,  $urandom);
        send_command(mts_pkg::CMD_POP,  $urandom);
        send_command(mts_pkg::CMD_MAX,  $urandom);
        send_command(mts_pkg::CMD_POP,  $urandom);
        send_command(mts_pkg::CMD_POP,  $urandom);
        send_command(mts_pkg::CMD_PUSH, 32'h0000_0000);
        send_command(mts_pkg::CMD_PUSH, 32'h0000_0001);
        send_command(mts_pkg::CMD_PUSH, 32'hFFFF_FFFB);
        send_command(mts_pkg::CMD_MAX,  $urandom);
        send_command(mts_pkg::CMD_TOP,  $urandom);

        for (int unsigned b = 0; b < BURSTS; b++) begin
            idle_phase = (b / 3) % 4;
            for (int unsigned n = 0; n < BURST_LEN; n++)
                send_command(pick_command(b % 3), pick_value());
        end
        cmd_if.valid <= 1'b0;
        idle_phase = 0;

        waited = 0;
        while (tracker.pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);

        if (tracker.pending_replies.size() != 0)
            $display("%0t: %0d expected replies never arrived",
                     $time, tracker.pending_replies.size());
        $display("Ran %0d commands, %0d replies: %0d pushes stored, %0d refused when full",
                 tracker.commands_taken, tracker.replies_seen,
                 tracker.pushes_stored, tracker.pushes_refused);
        $display("%0d empty-stack replies, deepest fill %0d of %0d, all gap/stall mixes",
                 tracker.empty_replies, tracker.deepest, STACK_DEPTH);
        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
            $display("PASS max_tracking_stack");
        end else begin
            $display("FAIL max_tracking_stack");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("run timed out");
        $display("FAIL max_tracking_stack");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mts_pkg.sv
rtl/core/mts_if.sv
rtl/core/mts_ctrl.sv
rtl/core/mts_dp.sv
rtl/core/max_tracking_stack.sv
tb/tb_top.sv
